// ===== rtl/sqd_pkg.sv =====
// Shared types and constants for the shortest-queue dispatcher.
// Used by sqd_window_table and shortest_queue_dispatcher; depends on nothing.
package sqd_pkg;

  localparam int unsigned WINDOWS_DEF      = 8;
  localparam int unsigned CAPACITY_MAX_DEF = 8;
  localparam int unsigned MAX_RESULTS      = 64;

  localparam int unsigned QC_W      = 8;
  localparam int unsigned SRV_W     = 16;
  localparam int unsigned BUSY_W    = 32;
  localparam int unsigned WAIT_W    = 10;
  localparam int unsigned TGT_W     = 3;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned WIDX_W    = 3;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PROD_W    = SRV_W + BUSY_W + 1;

  localparam logic [CFG_W-1:0] ACTIVE_RST = 4'd8;
  localparam logic [CFG_W-1:0] CAP_RST    = 4'd8;

  typedef enum logic [0:0] {
    OP_SET      = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE   = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_SCAN,
    ST_RATIO,
    ST_ASSIGN
  } state_e;

  typedef struct packed {
    logic [QC_W-1:0]   qc;
    logic [SRV_W-1:0]  served;
    logic [BUSY_W-1:0] busy;
    logic              open;
  } rec_t;

endpackage

// ===== rtl/sqd_window_table.sv =====
// Window record table: one write port, one read port and the open flags.
// Depends on sqd_pkg for the record type.
module sqd_window_table #(
  parameter int unsigned WINDOWS = sqd_pkg::WINDOWS_DEF,
  localparam int unsigned IW     = $clog2(WINDOWS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [IW-1:0]      wr_idx_i,
  input  sqd_pkg::rec_t      wr_rec_i,
  input  logic [IW-1:0]      rd_idx_i,
  output sqd_pkg::rec_t      rd_rec_o,
  output logic [WINDOWS-1:0] open_o
);

  sqd_pkg::rec_t tbl_q [WINDOWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOWS; i++) begin
        tbl_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      tbl_q[wr_idx_i] <= wr_rec_i;
    end
  end

  assign rd_rec_o = tbl_q[rd_idx_i];

  always_comb begin
    for (int i = 0; i < WINDOWS; i++) begin
      open_o[i] = tbl_q[i].open;
    end
  end

endmodule

// ===== rtl/shortest_queue_dispatcher.sv =====
// Shortest-queue dispatcher top level: sequencer, shared ratio multiplier, config.
// Depends on sqd_pkg and sqd_window_table.
//
//  channel   | signals                                         | flow
//  ----------+-------------------------------------------------+------------------
//  command   | start, busy, operation_i .. close_mask_i        | taken on start&&!busy
//  result    | res_stb_o, assigned_o, target_window_o, ...     | one cycle per strobe
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i                | written when cfg_we_i
//
// A set transfer writes the record and strobes its acknowledge on the next cycle.
// A dispatch first sums the eligible queues over every window, then checks for room; each customer
// then takes a scan over every window, with a ratio step per queue-length tie for the second
// product of the shared ratio multiplier, and an update step that emits the result.
// Reset closes every window, zeroes all records and sets both registers to 8.
// Results cannot be stalled; busy drops in the cycle the final result is strobed.
module shortest_queue_dispatcher #(
  parameter int unsigned WINDOWS      = sqd_pkg::WINDOWS_DEF,
  parameter int unsigned CAPACITY_MAX = sqd_pkg::CAPACITY_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic [sqd_pkg::WIDX_W-1:0]    window_index_i,
  input  logic [sqd_pkg::QC_W-1:0]      queue_count_i,
  input  logic [sqd_pkg::SRV_W-1:0]     served_count_i,
  input  logic [sqd_pkg::BUSY_W-1:0]    busy_time_i,
  input  logic                          window_open_i,
  input  logic [sqd_pkg::WAIT_W-1:0]    waiting_i,
  input  logic [sqd_pkg::MASK_W-1:0]    close_mask_i,
  input  logic                          cfg_we_i,
  input  logic [sqd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sqd_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                          res_stb_o,
  output logic                          assigned_o,
  output logic [sqd_pkg::TGT_W-1:0]     target_window_o,
  output logic [sqd_pkg::WAIT_W-1:0]    waiting_left_o,
  output logic                          last_o
);

  localparam int unsigned IW  = $clog2(WINDOWS);
  localparam int unsigned TW  = $clog2(WINDOWS * 255 + sqd_pkg::MAX_RESULTS + 1);
  localparam int unsigned NRW = $clog2(sqd_pkg::MAX_RESULTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOWS - 1);

  sqd_pkg::state_e state_q, state_d;

  logic [sqd_pkg::CFG_W-1:0]  active_q, cap_q, cap_sat;
  logic [sqd_pkg::WAIT_W-1:0] waiting_q, waiting_d;
  logic [WINDOWS-1:0]         elig_q, elig_d;
  logic [IW-1:0]              idx_q, idx_d;
  logic                       found_q, found_d;
  logic [IW-1:0]              best_idx_q, best_idx_d;
  sqd_pkg::rec_t              best_q, best_d;
  logic [TW-1:0]              total_q, total_d, need_q, need_d;
  logic [NRW-1:0]             n_q, n_d;
  logic [sqd_pkg::PROD_W-1:0] prod_q, prod_d;

  logic                       stb_q, stb_d, assigned_q, assigned_d, last_q, last_d;
  logic [sqd_pkg::TGT_W-1:0]  tgt_q, tgt_d;
  logic [sqd_pkg::WAIT_W-1:0] left_q, left_d;

  logic                       accept, in_range, go, fin, tie, take, idx_end;
  logic [WINDOWS+7:0]         mask_ext;
  logic [WINDOWS-1:0]         open_vec;

  logic                       wr_en;
  logic [IW-1:0]              wr_idx;
  sqd_pkg::rec_t              wr_rec, rd_rec;

  logic [sqd_pkg::SRV_W-1:0]  mul_a;
  logic [sqd_pkg::BUSY_W-1:0] mul_b;
  logic [sqd_pkg::PROD_W-1:0] mul_p;

  sqd_window_table #(
    .WINDOWS(WINDOWS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_idx_i (wr_idx),
    .wr_rec_i (wr_rec),
    .rd_idx_i (idx_q),
    .rd_rec_o (rd_rec),
    .open_o   (open_vec)
  );

  assign busy     = (state_q != sqd_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(window_index_i) < WINDOWS);
  assign mask_ext = (WINDOWS + 8)'(close_mask_i);
  assign cap_sat  = (32'(cap_q) > CAPACITY_MAX) ? sqd_pkg::CFG_W'(CAPACITY_MAX) : cap_q;
  assign go       = (total_q < need_q) && (waiting_q != '0);
  assign fin      = !(((total_q + TW'(1)) < need_q) && (waiting_q != sqd_pkg::WAIT_W'(1)) &&
                      ((n_q + NRW'(1)) < NRW'(sqd_pkg::MAX_RESULTS)));
  assign idx_end  = (idx_q == LAST_IDX);
  assign tie      = elig_q[idx_q] && found_q && (rd_rec.qc == best_q.qc);

  // Shared ratio multiplier: served_x * (busy_y + 1).
  always_comb begin
    if (state_q == sqd_pkg::ST_RATIO) begin
      mul_a = best_q.served;
      mul_b = rd_rec.busy;
    end else begin
      mul_a = rd_rec.served;
      mul_b = best_q.busy;
    end
  end
  assign mul_p = sqd_pkg::PROD_W'(mul_a) *
                 (sqd_pkg::PROD_W'(mul_b) + sqd_pkg::PROD_W'(1));

  // Candidate replaces the best when none is held yet, on a shorter queue, or when it strictly wins the ratio compare.
  always_comb begin
    take = 1'b0;
    if (state_q == sqd_pkg::ST_RATIO) begin
      take = (prod_q > mul_p);
    end else if (elig_q[idx_q]) begin
      take = !found_q || (rd_rec.qc < best_q.qc);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sqd_pkg::ST_IDLE: begin
        if (accept && (operation_i == sqd_pkg::OP_DISPATCH)) state_d = sqd_pkg::ST_SUM;
      end
      sqd_pkg::ST_SUM: begin
        if (idx_end) state_d = sqd_pkg::ST_CHECK;
      end
      sqd_pkg::ST_CHECK: begin
        state_d = go ? sqd_pkg::ST_SCAN : sqd_pkg::ST_IDLE;
      end
      sqd_pkg::ST_SCAN: begin
        if (tie) state_d = sqd_pkg::ST_RATIO;
        else if (idx_end) state_d = sqd_pkg::ST_ASSIGN;
      end
      sqd_pkg::ST_RATIO: begin
        state_d = idx_end ? sqd_pkg::ST_ASSIGN : sqd_pkg::ST_SCAN;
      end
      sqd_pkg::ST_ASSIGN: begin
        state_d = fin ? sqd_pkg::ST_IDLE : sqd_pkg::ST_SCAN;
      end
      default: state_d = sqd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result control.
  always_comb begin
    waiting_d  = waiting_q;
    elig_d     = elig_q;
    idx_d      = idx_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    total_d    = total_q;
    need_d     = need_q;
    n_d        = n_q;
    prod_d     = prod_q;
    stb_d      = 1'b0;
    assigned_d = assigned_q;
    tgt_d      = tgt_q;
    left_d     = left_q;
    last_d     = last_q;
    wr_en      = 1'b0;
    wr_idx     = IW'(window_index_i);
    wr_rec     = '{qc: queue_count_i, served: served_count_i,
                   busy: busy_time_i, open: window_open_i};

    case (state_q)
      sqd_pkg::ST_IDLE: begin
        if (accept) begin
          if (operation_i == sqd_pkg::OP_DISPATCH) begin
            waiting_d = waiting_i;
            for (int i = 0; i < WINDOWS; i++) begin
              elig_d[i] = (32'(i) < 32'(active_q)) && open_vec[i] && !mask_ext[i];
            end
            idx_d   = '0;
            total_d = '0;
            need_d  = '0;
            n_d     = '0;
          end else begin
            wr_en      = in_range;
            stb_d      = 1'b1;
            assigned_d = 1'b0;
            tgt_d      = window_index_i;
            left_d     = '0;
            last_d     = 1'b1;
          end
        end
      end
      sqd_pkg::ST_SUM: begin
        if (elig_q[idx_q]) begin
          total_d = total_q + TW'(rd_rec.qc);
          need_d  = need_q + TW'(cap_sat);
        end
        idx_d = idx_end ? '0 : idx_q + IW'(1);
      end
      sqd_pkg::ST_CHECK: begin
        found_d = 1'b0;
        idx_d   = '0;
        if (!go) begin
          stb_d      = 1'b1;
          assigned_d = 1'b0;
          tgt_d      = '0;
          left_d     = waiting_q;
          last_d     = 1'b1;
        end
      end
      sqd_pkg::ST_SCAN, sqd_pkg::ST_RATIO: begin
        if (state_q == sqd_pkg::ST_SCAN && tie) begin
          // Hold the index; the second product follows next cycle.
          prod_d = mul_p;
        end else begin
          if (take) begin
            best_d     = rd_rec;
            best_idx_d = idx_q;
            found_d    = 1'b1;
          end
          idx_d = idx_end ? '0 : idx_q + IW'(1);
        end
      end
      sqd_pkg::ST_ASSIGN: begin
        wr_en      = 1'b1;
        wr_idx     = best_idx_q;
        wr_rec     = best_q;
        wr_rec.qc  = best_q.qc + sqd_pkg::QC_W'(1);
        total_d    = total_q + TW'(1);
        waiting_d  = waiting_q - sqd_pkg::WAIT_W'(1);
        n_d        = n_q + NRW'(1);
        stb_d      = 1'b1;
        assigned_d = 1'b1;
        tgt_d      = sqd_pkg::TGT_W'(best_idx_q);
        left_d     = waiting_q - sqd_pkg::WAIT_W'(1);
        last_d     = fin;
        found_d    = 1'b0;
        idx_d      = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sqd_pkg::ST_IDLE;
      active_q <= sqd_pkg::ACTIVE_RST;
      cap_q    <= sqd_pkg::CAP_RST;
      stb_q    <= 1'b0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      elig_q   <= '0;
      total_q  <= '0;
      need_q   <= '0;
      n_q      <= '0;
    end else begin
      state_q <= state_d;
      stb_q   <= stb_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      elig_q  <= elig_d;
      total_q <= total_d;
      need_q  <= need_d;
      n_q     <= n_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sqd_pkg::CFG_ACTIVE:   active_q <= cfg_wdata_i;
          sqd_pkg::CFG_CAPACITY: cap_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    waiting_q  <= waiting_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    prod_q     <= prod_d;
    assigned_q <= assigned_d;
    tgt_q      <= tgt_d;
    left_q     <= left_d;
    last_q     <= last_d;
  end

  assign res_stb_o       = stb_q;
  assign assigned_o      = assigned_q;
  assign target_window_o = tgt_q;
  assign waiting_left_o  = left_q;
  assign last_o          = last_q;

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_stb_o && !last_o |-> busy)
    else $error("non-final result strobed while idle");

  a_set_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (operation_i == sqd_pkg::OP_SET) |=>
      res_stb_o && last_o && !assigned_o)
    else $error("set transfer not acknowledged");

  a_room_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sqd_pkg::ST_SCAN) || (state_q == sqd_pkg::ST_RATIO) |->
      total_q < need_q)
    else $error("scan running without free room");

  a_pick_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sqd_pkg::ST_ASSIGN) |-> found_q && (32'(best_q.qc) < 32'(cap_sat)))
    else $error("chosen window already at capacity");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for shortest_queue_dispatcher: command driver, result monitor, predictor.
// Depends on sqd_pkg and the dispatcher RTL; register settings sweep through phases between
// bursts of window writes and dispatches.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    sqd_pkg::op_e                op;
    logic [sqd_pkg::WIDX_W-1:0]  widx;
    logic [sqd_pkg::QC_W-1:0]    qc;
    logic [sqd_pkg::SRV_W-1:0]   served;
    logic [sqd_pkg::BUSY_W-1:0]  busy_t;
    logic                        open;
    logic [sqd_pkg::WAIT_W-1:0]  waiting;
    logic [sqd_pkg::MASK_W-1:0]  mask;
  } cmd_t;

  typedef struct {
    logic                       assigned;
    logic [sqd_pkg::TGT_W-1:0]  target;
    logic [sqd_pkg::WAIT_W-1:0] wait_left;
    logic                       last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic operation_i = 1'b0;
  logic [sqd_pkg::WIDX_W-1:0] window_index_i = '0;
  logic [sqd_pkg::QC_W-1:0] queue_count_i = '0;
  logic [sqd_pkg::SRV_W-1:0] served_count_i = '0;
  logic [sqd_pkg::BUSY_W-1:0] busy_time_i = '0;
  logic window_open_i = 1'b0;
  logic [sqd_pkg::WAIT_W-1:0] waiting_i = '0;
  logic [sqd_pkg::MASK_W-1:0] close_mask_i = '0;
  logic cfg_we_i = 1'b0;
  logic [sqd_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [sqd_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic res_stb_o;
  logic assigned_o;
  logic [sqd_pkg::TGT_W-1:0] target_window_o;
  logic [sqd_pkg::WAIT_W-1:0] waiting_left_o;
  logic last_o;

  shortest_queue_dispatcher dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .window_index_i (window_index_i),
    .queue_count_i  (queue_count_i),
    .served_count_i (served_count_i),
    .busy_time_i    (busy_time_i),
    .window_open_i  (window_open_i),
    .waiting_i      (waiting_i),
    .close_mask_i   (close_mask_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .res_stb_o      (res_stb_o),
    .assigned_o     (assigned_o),
    .target_window_o(target_window_o),
    .waiting_left_o (waiting_left_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Window table and register copies, as they stand after every accepted command.
  logic [sqd_pkg::QC_W-1:0]   win_qc     [sqd_pkg::WINDOWS_DEF] = '{default: '0};
  logic [sqd_pkg::SRV_W-1:0]  win_served [sqd_pkg::WINDOWS_DEF] = '{default: '0};
  logic [sqd_pkg::BUSY_W-1:0] win_busy   [sqd_pkg::WINDOWS_DEF] = '{default: '0};
  logic                       win_open   [sqd_pkg::WINDOWS_DEF] = '{default: 1'b0};
  logic [sqd_pkg::CFG_W-1:0]  reg_active = sqd_pkg::ACTIVE_RST;
  logic [sqd_pkg::CFG_W-1:0]  reg_cap    = sqd_pkg::CAP_RST;

  cmd_t    cmd_queue[$];
  result_t expected_results[$];
  cmd_t    cur_cmd;

  int unsigned gap_left = 0;
  int unsigned calm_left = 0;
  int unsigned errors = 0;
  int unsigned n_cmds = 0;
  int unsigned n_dispatch = 0;
  int unsigned n_results = 0;
  int unsigned n_placed = 0;
  int unsigned n_cfg = 0;

  // True when window a has the better served/(busy+1) rate than window b.
  function automatic bit rate_beats(int unsigned a, int unsigned b);
    logic [63:0] lhs, rhs;
    lhs = 64'(win_served[a]) * (64'(win_busy[b]) + 64'd1);
    rhs = 64'(win_served[b]) * (64'(win_busy[a]) + 64'd1);
    return lhs > rhs;
  endfunction

  // Apply one accepted command to the table copy and queue the results it causes.
  task automatic predict_transfer(input cmd_t c);
    int unsigned used, cap, total, need, n, best;
    logic [sqd_pkg::WAIT_W-1:0] left;
    bit elig [sqd_pkg::WINDOWS_DEF];
    bit found;
    if (c.op == sqd_pkg::OP_SET) begin
      win_qc[c.widx] = c.qc;
      win_served[c.widx] = c.served;
      win_busy[c.widx] = c.busy_t;
      win_open[c.widx] = c.open;
      expected_results.push_back('{1'b0, c.widx, '0, 1'b1});
    end else begin
      used = (reg_active > sqd_pkg::WINDOWS_DEF) ? sqd_pkg::WINDOWS_DEF : reg_active;
      cap = (reg_cap > sqd_pkg::CAPACITY_MAX_DEF) ? sqd_pkg::CAPACITY_MAX_DEF : reg_cap;
      total = 0;
      need = 0;
      n = 0;
      left = c.waiting;
      for (int unsigned i = 0; i < sqd_pkg::WINDOWS_DEF; i++) begin
        elig[i] = (i < used) && win_open[i] && !c.mask[i];
        if (elig[i]) begin
          total += win_qc[i];
          need += cap;
        end
      end
      while (total < need && left != 0 && n < sqd_pkg::MAX_RESULTS) begin
        found = 1'b0;
        best = 0;
        for (int unsigned i = 0; i < sqd_pkg::WINDOWS_DEF; i++) begin
          if (elig[i] && (!found || win_qc[i] < win_qc[best] ||
                          (win_qc[i] == win_qc[best] && rate_beats(i, best)))) begin
            best = i;
            found = 1'b1;
          end
        end
        win_qc[best] = win_qc[best] + 1'b1;
        total++;
        left--;
        expected_results.push_back('{1'b1, sqd_pkg::TGT_W'(best), left, 1'b0});
        n++;
      end
      if (n == 0) expected_results.push_back('{1'b0, '0, left, 1'b1});
      else expected_results[expected_results.size() - 1].last = 1'b1;
    end
  endtask

  // Unused fields of each command carry noise.
  function automatic cmd_t set_cmd(int unsigned widx, int unsigned qc, int unsigned served,
                                   logic [sqd_pkg::BUSY_W-1:0] busy_t, bit open);
    cmd_t c;
    c.op = sqd_pkg::OP_SET;
    c.widx = sqd_pkg::WIDX_W'(widx);
    c.qc = sqd_pkg::QC_W'(qc);
    c.served = sqd_pkg::SRV_W'(served);
    c.busy_t = busy_t;
    c.open = open;
    c.waiting = sqd_pkg::WAIT_W'($urandom_range(0, 1023));
    c.mask = sqd_pkg::MASK_W'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic cmd_t dispatch_cmd(int unsigned waiting, int unsigned mask);
    cmd_t c;
    c.op = sqd_pkg::OP_DISPATCH;
    c.widx = sqd_pkg::WIDX_W'($urandom_range(0, 7));
    c.qc = sqd_pkg::QC_W'($urandom_range(0, 255));
    c.served = sqd_pkg::SRV_W'($urandom_range(0, 65535));
    c.busy_t = $urandom;
    c.open = 1'($urandom_range(0, 1));
    c.waiting = sqd_pkg::WAIT_W'(waiting);
    c.mask = sqd_pkg::MASK_W'(mask);
    return c;
  endfunction

  // Mostly low queues on open windows so dispatches have room; small served and
  // busy values make exact rate ties common.
  function automatic cmd_t random_cmd();
    int unsigned cap, qc, served, mask;
    logic [sqd_pkg::BUSY_W-1:0] busy_t;
    cap = (reg_cap > sqd_pkg::CAPACITY_MAX_DEF) ? sqd_pkg::CAPACITY_MAX_DEF : reg_cap;
    if ($urandom_range(0, 9) < 6) begin
      qc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, cap);
      case ($urandom_range(0, 2))
        0: begin served = $urandom_range(0, 65535); busy_t = $urandom; end
        1: begin served = $urandom_range(0, 4); busy_t = $urandom_range(0, 4); end
        default: begin served = $urandom_range(0, 65535); busy_t = $urandom_range(0, 9); end
      endcase
      return set_cmd($urandom_range(0, 7), qc, served, busy_t, $urandom_range(0, 7) != 0);
    end
    case ($urandom_range(0, 3))
      1: mask = 1 << $urandom_range(0, 7);
      2: mask = $urandom_range(0, 255);
      default: mask = 0;
    endcase
    return dispatch_cmd(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 24), mask);
  endfunction

  // Command driver: hold each command until a transfer, then idle for a randomly drawn gap.
  always @(posedge clk_i) begin : driver
    bit hold;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      hold = start;
      if (start && !busy) begin
        predict_transfer(cur_cmd);
        n_cmds++;
        if (cur_cmd.op == sqd_pkg::OP_DISPATCH) n_dispatch++;
        hold = 1'b0;
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 18);
          if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(6, 20);
        end
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() != 0) begin
          cur_cmd = cmd_queue.pop_front();
          hold = 1'b1;
          operation_i <= cur_cmd.op;
          window_index_i <= cur_cmd.widx;
          queue_count_i <= cur_cmd.qc;
          served_count_i <= cur_cmd.served;
          busy_time_i <= cur_cmd.busy_t;
          window_open_i <= cur_cmd.open;
          waiting_i <= cur_cmd.waiting;
          close_mask_i <= cur_cmd.mask;
        end
      end
      start <= hold;
    end
  end

  task automatic report_field(string name, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin : monitor
    result_t got, want;
    if (rst_ni && res_stb_o) begin
      got = '{assigned_o, target_window_o, waiting_left_o, last_o};
      n_results++;
      if (got.assigned) n_placed++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d window %0d left %0d last %0d",
                 $time, got.assigned, got.target, got.wait_left, got.last);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.assigned !== want.assigned) report_field("assigned", want.assigned, got.assigned);
        if (got.target !== want.target) report_field("target_window", want.target, got.target);
        if (got.wait_left !== want.wait_left)
          report_field("waiting_left", want.wait_left, got.wait_left);
        if (got.last !== want.last) report_field("last", want.last, got.last);
      end
    end
  end

  // Block is idle once every command is taken and every result has come back.
  task automatic settle();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || start || expected_results.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_register(sqd_pkg::cfg_reg_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= sqd_pkg::CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sqd_pkg::CFG_ACTIVE) reg_active = sqd_pkg::CFG_W'(value);
    else reg_cap = sqd_pkg::CFG_W'(value);
    n_cfg++;
  endtask

  initial begin : stimulus
    int unsigned phase_active [8] = '{1, 0, 15, 3, 8, 12, 2, 8};
    int unsigned phase_cap    [8] = '{1, 8, 15, 5, 1, 0, 8, 8};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every window starts closed: nothing can be dispatched.
    cmd_queue.push_back(dispatch_cmd(7, 8'h00));
    cmd_queue.push_back(set_cmd(0, 0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    cmd_queue.push_back(set_cmd(1, 0, 0, 0, 1'b1));
    cmd_queue.push_back(set_cmd(2, 0, 16'hFFFF, 0, 1'b1));
    cmd_queue.push_back(set_cmd(3, 0, 1, 1, 1'b1));
    cmd_queue.push_back(set_cmd(4, 0, 2, 3, 1'b1));
    cmd_queue.push_back(set_cmd(5, 0, 0, 0, 1'b1));
    cmd_queue.push_back(set_cmd(6, 0, 100, 99, 1'b1));
    cmd_queue.push_back(set_cmd(7, 0, 3, 2, 1'b1));
    // Full room and a long line: stops at the per-dispatch result limit.
    cmd_queue.push_back(dispatch_cmd(1023, 8'h00));
    cmd_queue.push_back(dispatch_cmd(10, 8'h00));
    cmd_queue.push_back(set_cmd(7, 255, 16'hFFFF, 32'hFFFF_FFFF, 1'b0));
    cmd_queue.push_back(set_cmd(0, 0, 0, 0, 1'b1));
    cmd_queue.push_back(dispatch_cmd(0, 8'h00));
    cmd_queue.push_back(dispatch_cmd(1023, 8'hFE));
    cmd_queue.push_back(set_cmd(3, 255, 5, 7, 1'b1));
    cmd_queue.push_back(dispatch_cmd(5, 8'h00));
    cmd_queue.push_back(dispatch_cmd(3, 8'hFF));
    cmd_queue.push_back(set_cmd(1, 7, 0, 0, 1'b0));
    cmd_queue.push_back(set_cmd(3, 0, 5, 7, 1'b1));
    cmd_queue.push_back(dispatch_cmd(1, 8'h01));
    settle();

    foreach (phase_active[p]) begin
      write_register(sqd_pkg::CFG_ACTIVE, phase_active[p]);
      write_register(sqd_pkg::CFG_CAPACITY, phase_cap[p]);
      repeat (14) cmd_queue.push_back(random_cmd());
      settle();
    end

    repeat (20) @(negedge clk_i);
    errors += expected_results.size();
    $display("covered %0d commands (%0d dispatches), %0d results, %0d customers placed",
             n_cmds, n_dispatch, n_results, n_placed);
    $display("%0d register writes across %0d register settings", n_cfg, $size(phase_active) + 1);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("testbench: errors");
    $finish;
  end

endmodule
